// ===== hw/rtl/blps_pkg.sv =====
`timescale 1ns / 1ps

package blps_pkg;

	// Field widths fixed by the interface
	localparam int COORD_W = 12;
	localparam int DELTA_W = 13;
	localparam int ERR_W   = 14;
	localparam int COLOR_W = 3;
	localparam int ADDR_W  = 18;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [DELTA_W-1:0] delta_t;
	typedef logic signed [DELTA_W-1:0] sdelta_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic        [COLOR_W-1:0] color_t;

	// Request kinds
	typedef enum logic [0:0] {
		KIND_LOAD = 1'b0,
		KIND_STEP = 1'b1
	} kind_t;

endpackage

// ===== hw/rtl/bresenham_line_pixel_stepper_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   kind, x_start, y_start, x_end, y_end, pen_color
// out      out_valid / out_ready byte_address, upper_half, color_out, is_last
//
// One request per clock. A step request on an active line reads the walk
// registers, forms the clamped pixel address (constant multiply by SCREEN_WIDTH
// plus add) and writes the result register in the same cycle; a load request
// sets up the walk. in_ready is low only while a result is held and out_ready
// is low. arst_n clears the walk (no active line) and the result valid.
module bresenham_line_pixel_stepper_unit #(
	parameter int SCREEN_WIDTH  = 640,
	parameter int SCREEN_HEIGHT = 480
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic signed [blps_pkg::COORD_W-1:0] x_start,
	input  logic signed [blps_pkg::COORD_W-1:0] y_start,
	input  logic signed [blps_pkg::COORD_W-1:0] x_end,
	input  logic signed [blps_pkg::COORD_W-1:0] y_end,
	input  logic        [blps_pkg::COLOR_W-1:0] pen_color,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic        [blps_pkg::ADDR_W-1:0]  byte_address,
	output logic                                upper_half,
	output logic        [blps_pkg::COLOR_W-1:0] color_out,
	output logic                                is_last
);

	localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
	localparam int YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
	localparam int PIX_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

	localparam logic signed [blps_pkg::DELTA_W-1:0] X_MAX =
		blps_pkg::DELTA_W'(SCREEN_WIDTH - 1);
	localparam logic signed [blps_pkg::DELTA_W-1:0] Y_MAX =
		blps_pkg::DELTA_W'(SCREEN_HEIGHT - 1);
	localparam logic [XW-1:0]    X_MAX_U = XW'(SCREEN_WIDTH - 1);
	localparam logic [YW-1:0]    Y_MAX_U = YW'(SCREEN_HEIGHT - 1);
	localparam logic [PIX_W-1:0] WIDTH_C = PIX_W'(SCREEN_WIDTH);

	// Walk state
	logic                     active_q;
	logic                     steep_q;
	blps_pkg::coord_t         major_pos_q;
	blps_pkg::coord_t         major_end_q;
	blps_pkg::coord_t         minor_pos_q;
	logic                     step_down_q;
	blps_pkg::err_t           error_q;
	blps_pkg::delta_t         dmaj_q;
	blps_pkg::delta_t         dmin_q;
	blps_pkg::color_t         color_q;

	// Result register
	logic                     out_valid_q;
	logic [blps_pkg::ADDR_W-1:0] addr_q;
	logic                     upper_q;
	blps_pkg::color_t         color_out_q;
	logic                     last_q;

	logic in_acc;
	logic is_load;
	logic emit;

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign is_load  = (blps_pkg::kind_t'(kind) == blps_pkg::KIND_LOAD);
	assign emit     = in_acc && !is_load && active_q;

	// Load setup: steep test, axis swap, endpoint ordering
	blps_pkg::sdelta_t dx_s, dy_s;
	blps_pkg::delta_t  adx, ady;
	logic              steep;
	blps_pkg::coord_t  a0, b0, a1, b1;
	blps_pkg::coord_t  ma0, mb0, ma1, mb1;
	blps_pkg::sdelta_t da_s, db_s;
	blps_pkg::delta_t  ld_dmaj, ld_dmin;

	always_comb begin
		dx_s  = blps_pkg::DELTA_W'(x_end) - blps_pkg::DELTA_W'(x_start);
		dy_s  = blps_pkg::DELTA_W'(y_end) - blps_pkg::DELTA_W'(y_start);
		adx   = dx_s[blps_pkg::DELTA_W-1] ? blps_pkg::delta_t'(-dx_s) : blps_pkg::delta_t'(dx_s);
		ady   = dy_s[blps_pkg::DELTA_W-1] ? blps_pkg::delta_t'(-dy_s) : blps_pkg::delta_t'(dy_s);
		steep = ady > adx;
		if (steep) begin
			a0 = y_start; b0 = x_start; a1 = y_end; b1 = x_end;
		end else begin
			a0 = x_start; b0 = y_start; a1 = x_end; b1 = y_end;
		end
		if (a0 > a1) begin
			ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
		end else begin
			ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
		end
		da_s    = blps_pkg::DELTA_W'(ma1) - blps_pkg::DELTA_W'(ma0);
		db_s    = blps_pkg::DELTA_W'(mb1) - blps_pkg::DELTA_W'(mb0);
		ld_dmaj = blps_pkg::delta_t'(da_s);
		ld_dmin = db_s[blps_pkg::DELTA_W-1] ? blps_pkg::delta_t'(-db_s) : blps_pkg::delta_t'(db_s);
	end

	// Pixel position, clamped to the screen
	blps_pkg::coord_t  px, py;
	blps_pkg::sdelta_t px_w, py_w;
	logic [XW-1:0]     px_c;
	logic [YW-1:0]     py_c;
	logic [PIX_W-1:0]  pixel;
	logic [PIX_W+blps_pkg::ADDR_W-1:0] pixel_ext;
	logic              last;

	always_comb begin
		px   = steep_q ? minor_pos_q : major_pos_q;
		py   = steep_q ? major_pos_q : minor_pos_q;
		px_w = blps_pkg::DELTA_W'(px);
		py_w = blps_pkg::DELTA_W'(py);
		if (px_w[blps_pkg::DELTA_W-1])
			px_c = '0;
		else if (px_w > X_MAX)
			px_c = X_MAX_U;
		else
			px_c = px_w[XW-1:0];
		if (py_w[blps_pkg::DELTA_W-1])
			py_c = '0;
		else if (py_w > Y_MAX)
			py_c = Y_MAX_U;
		else
			py_c = py_w[YW-1:0];
		pixel     = PIX_W'(PIX_W'(py_c) * WIDTH_C) + PIX_W'(px_c);
		pixel_ext = {{blps_pkg::ADDR_W{1'b0}}, pixel};
		last      = (major_pos_q == major_end_q);
	end

	// Error update for one step
	blps_pkg::err_t err_sub, err_next;

	always_comb begin
		err_sub  = error_q - blps_pkg::err_t'({1'b0, dmin_q});
		err_next = err_sub[blps_pkg::ERR_W-1] ?
			err_sub + blps_pkg::err_t'({1'b0, dmaj_q}) : err_sub;
	end

	// Walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			steep_q     <= 1'b0;
			major_pos_q <= '0;
			major_end_q <= '0;
			minor_pos_q <= '0;
			step_down_q <= 1'b0;
			error_q     <= '0;
			dmaj_q      <= '0;
			dmin_q      <= '0;
			color_q     <= '0;
		end else if (in_acc && is_load) begin
			active_q    <= 1'b1;
			steep_q     <= steep;
			major_pos_q <= ma0;
			major_end_q <= ma1;
			minor_pos_q <= mb0;
			step_down_q <= !(mb0 < mb1);
			error_q     <= blps_pkg::err_t'(ld_dmaj >> 1);
			dmaj_q      <= ld_dmaj;
			dmin_q      <= ld_dmin;
			color_q     <= pen_color;
		end else if (emit) begin
			error_q <= err_next;
			if (err_sub[blps_pkg::ERR_W-1])
				minor_pos_q <= step_down_q ? minor_pos_q - 12'sd1 : minor_pos_q + 12'sd1;
			if (last)
				active_q <= 1'b0;
			else
				major_pos_q <= major_pos_q + 12'sd1;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			addr_q      <= pixel_ext[blps_pkg::ADDR_W:1];
			upper_q     <= pixel[0];
			color_out_q <= color_q;
			last_q      <= last;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_address = addr_q;
	assign upper_half   = upper_q;
	assign color_out    = color_out_q;
	assign is_last      = last_q;

`ifndef SYNTHESIS
	// Error term never stays negative between steps
	a_err_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!error_q[blps_pkg::ERR_W-1])
		else $error("error term negative");

	// A load always leaves an active line
	a_load_active: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_load |=> active_q)
		else $error("load did not start a line");

	// The final pixel ends the line
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last |=> !active_q && out_valid_q && last_q)
		else $error("last pixel did not end the line");

	// A non-final step advances the major axis by one
	a_major_adv: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !last |=> major_pos_q == $past(major_pos_q) + 12'sd1)
		else $error("major position did not advance");

	// A request that emits nothing does not create a result
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!emit |=> out_valid_q == $past(out_valid_q && !out_ready))
		else $error("result appeared without a step");
`endif

endmodule
